// File: rtl/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, command codes and character constants for the integer to
// ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int unsigned VALUE_W = 32;

  // command codes
  localparam logic [1:0] CMD_UNSIGNED = 2'd0;
  localparam logic [1:0] CMD_SIGNED   = 2'd1;
  localparam logic [1:0] CMD_HEX      = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // ASCII
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_X     = 8'h78;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_UC_A  = 8'h41;

  // n / 10 == (n * RECIP_DIV10) >> DIV10_SHIFT for every 32-bit n
  localparam logic [VALUE_W-1:0] RECIP_DIV10 = 32'hCCCC_CCCD;
  localparam int unsigned        DIV10_SHIFT = 35;

  // hex text: "0x" plus eight nibbles
  localparam logic [3:0] HEX_CHARS_M1 = 4'd9;
  localparam logic [3:0] HEX_PREFIX0  = 4'd9;
  localparam logic [3:0] HEX_PREFIX1  = 4'd8;

  localparam int unsigned JOBQ_DEPTH = 2;

  typedef enum logic {
    KIND_DEC,
    KIND_HEX
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = ASCII_ZERO + {4'd0, nib};
    end else begin
      ch = ASCII_UC_A + {4'd0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

// File: rtl/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats a 32-bit number as unsigned decimal, signed decimal or "0x" hex
// text and delivers it one ASCII character per result.
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  input     push / full    cmd[1:0], value[31:0]
//  result    pop / empty    char_code[7:0], last
//
//  Hex request: load, then 10 characters at one per cycle when not stalled.
//  Decimal request with d digits: load, d divides by ten (one per cycle),
//  then d characters, one more for the minus sign.
//  Up to two requests wait in the job queue while the back end works.
//  Reserved command produces no characters. Reset empties queue and output.
//  A character held on the outputs stalls the back end until popped.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top #(
  parameter int unsigned MAX_DECIMAL_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [31:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  char_code,
  output logic        last
);
  import ita_pkg::*;

  logic wr_en;
  job_t wr_job;
  logic rd_en;
  job_t rd_job;
  logic q_empty;

  ita_front u_front (
    .push  (push),
    .full  (full),
    .cmd   (cmd),
    .value (value),
    .wr_en (wr_en),
    .job   (wr_job)
  );

  ita_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_job (wr_job),
    .rd_en  (rd_en),
    .rd_job (rd_job),
    .full   (full),
    .empty  (q_empty)
  );

  ita_back #(
    .MAX_DECIMAL_DIGITS (MAX_DECIMAL_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (rd_job),
    .job_empty (q_empty),
    .job_rd    (rd_en),
    .pop       (pop),
    .empty     (empty),
    .char_code (char_code),
    .last      (last)
  );

endmodule

// File: rtl/ita_front.sv
// ----------------------------------------------------------------------------
// ita_front
// Accepts requests, decodes the command and forms the job for the back end:
// kind, sign and magnitude. Requests with the reserved command are dropped.
// ----------------------------------------------------------------------------
module ita_front (
  input  logic                   push,
  input  logic                   full,
  input  logic [1:0]             cmd,
  input  logic [ita_pkg::VALUE_W-1:0] value,
  output logic                   wr_en,
  output ita_pkg::job_t          job
);
  import ita_pkg::*;

  logic take;

  assign take = push & ~full;

  always_comb begin
    job.kind = KIND_DEC;
    job.neg  = 1'b0;
    job.mag  = value;
    wr_en    = 1'b0;
    unique case (cmd)
      CMD_UNSIGNED: begin
        wr_en = take;
      end
      CMD_SIGNED: begin
        wr_en   = take;
        job.neg = value[VALUE_W-1];
        // magnitude in unsigned arithmetic, exact for the most negative value
        if (value[VALUE_W-1]) begin
          job.mag = ~value + VALUE_W'(1);
        end
      end
      CMD_HEX: begin
        wr_en    = take;
        job.kind = KIND_HEX;
      end
      CMD_RESERVED: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/ita_jobq.sv
// ----------------------------------------------------------------------------
// ita_jobq
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ita_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ita_pkg::job_t wr_job,
  input  logic          rd_en,
  output ita_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);
  import ita_pkg::*;

  localparam int unsigned PTR_W = $clog2(JOBQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             entries [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(JOBQ_DEPTH));
  assign empty  = (count == '0);
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      priority if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/ita_back.sv
// ----------------------------------------------------------------------------
// ita_back
// Takes jobs from the queue, extracts decimal digits one per cycle and
// emits the text one character at a time into the output register.
// ----------------------------------------------------------------------------
module ita_back #(
  parameter int unsigned MAX_DECIMAL_DIGITS = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  ita_pkg::job_t job,
  input  logic          job_empty,
  output logic          job_rd,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    char_code,
  output logic          last
);
  import ita_pkg::*;

  localparam int unsigned DIG_W = $clog2(MAX_DECIMAL_DIGITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t             state;
  job_kind_t          kind;
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [3:0]         digits [MAX_DECIMAL_DIGITS];
  logic [DIG_W-1:0]   dig_idx;
  logic [3:0]         hex_cnt;
  logic               out_valid;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [3:0]           rem;
  logic                 slot_free;
  logic                 emit;

  assign job_rd    = (state == ST_IDLE) && !job_empty;
  assign empty     = ~out_valid;
  assign slot_free = ~out_valid | pop;
  assign emit      = (state == ST_EMIT) && slot_free;

  // divide by ten through the reciprocal
  assign prod     = (2*VALUE_W)'(mag) * (2*VALUE_W)'(RECIP_DIV10);
  assign quot     = VALUE_W'(prod[2*VALUE_W-1:DIV10_SHIFT]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = 4'(mag - quot_x10);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit | (out_valid & ~pop);
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            kind    <= job.kind;
            neg     <= job.neg;
            mag     <= job.mag;
            dig_idx <= '0;
            hex_cnt <= HEX_CHARS_M1;
            state   <= (job.kind == KIND_HEX) ? ST_EMIT : ST_DIV;
          end
        end
        ST_DIV: begin
          digits[dig_idx] <= rem;
          mag             <= quot;
          if (quot == '0 || dig_idx == DIG_W'(MAX_DECIMAL_DIGITS - 1)) begin
            state <= ST_EMIT;
          end else begin
            dig_idx <= dig_idx + DIG_W'(1);
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (kind == KIND_HEX) begin
              priority if (hex_cnt == HEX_PREFIX0) begin
                char_code <= ASCII_ZERO;
              end else if (hex_cnt == HEX_PREFIX1) begin
                char_code <= ASCII_X;
              end else begin
                char_code <= hex_glyph(mag[VALUE_W-1 -: 4]);
                mag       <= mag << 4;
              end
              last    <= (hex_cnt == '0);
              hex_cnt <= hex_cnt - 4'd1;
              if (hex_cnt == '0) begin
                state <= ST_IDLE;
              end
            end else if (neg) begin
              char_code <= ASCII_MINUS;
              last      <= 1'b0;
              neg       <= 1'b0;
            end else begin
              char_code <= ASCII_ZERO + {4'd0, digits[dig_idx]};
              last      <= (dig_idx == '0);
              dig_idx   <= dig_idx - DIG_W'(1);
              if (dig_idx == '0) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
